// ===== rtl/qfa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; used by qfa_divider and q24_8_fixed_point_alu.
package qfa_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 8;
  localparam int unsigned DivW    = 40;  // dividend/divisor width of the divider array
  localparam int unsigned NumDivs = 4;   // one for div and first Newton step, three more

  typedef enum logic [2:0] {
    CMD_MUL   = 3'd0,
    CMD_DIV   = 3'd1,
    CMD_SQRT  = 3'd2,
    CMD_ABS   = 3'd3,
    CMD_TRUNC = 3'd4,
    CMD_ROUND = 3'd5
  } cmd_e;

  // Per-item sideband that rides along the divider pipeline.
  typedef struct packed {
    logic [2:0]       cmd;
    logic [DataW-1:0] res;     // result, final for all but div and sqrt
    logic             status;  // divide by zero
    logic [DivW-1:0]  s;       // square root radicand a<<8
    logic             neg;     // quotient sign for div
    logic             sqz;     // sqrt of zero or negative
  } sb_t;

endpackage

// ===== rtl/qfa_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on qfa_pkg for widths and the sideband type.
module qfa_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  qfa_pkg::sb_t          sb_i,
  input  logic [qfa_pkg::DivW-1:0] num_i,
  input  logic [qfa_pkg::DivW-1:0] den_i,
  output logic                  valid_o,
  output qfa_pkg::sb_t          sb_o,
  output logic [qfa_pkg::DivW-1:0] quo_o,
  output logic [qfa_pkg::DivW-1:0] den_o
);
  import qfa_pkg::*;

  logic            valid_q [DivW];
  sb_t             sb_q    [DivW];
  logic [DivW-1:0] rem_q   [DivW];
  logic [DivW-1:0] num_q   [DivW];
  logic [DivW-1:0] den_q   [DivW];
  logic [DivW-1:0] quo_q   [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic            valid_in;
    sb_t             sb_in;
    logic [DivW-1:0] rem_in, num_in, den_in, quo_in;
    logic [DivW:0]   trial, diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign sb_in    = sb_i;
      assign rem_in   = '0;
      assign num_in   = num_i;
      assign den_in   = den_i;
      assign quo_in   = '0;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign sb_in    = sb_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign num_in   = num_q[k-1];
      assign den_in   = den_q[k-1];
      assign quo_in   = quo_q[k-1];
    end

    // bring down the next dividend bit, subtract where it fits
    assign trial = {rem_in, num_in[DivW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[k]  <= sb_in;
        rem_q[k] <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
        num_q[k] <= {num_in[DivW-2:0], 1'b0};
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[DivW-2:0], ge};
      end
    end
  end

  assign valid_o = valid_q[DivW-1];
  assign sb_o    = sb_q[DivW-1];
  assign quo_o   = quo_q[DivW-1];
  assign den_o   = den_q[DivW-1];

endmodule

// ===== rtl/q24_8_fixed_point_alu.sv =====
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on qfa_pkg and qfa_divider.
//
// Fully pipelined ALU: while the output is not stalled, one beat is accepted
// every cycle, and every beat gives one result beat, in order. Every opcode
// runs through the whole pipe: one input stage, one multiplier stage, one
// operand stage, then four 40-stage divider arrays (bit-per-stage restoring
// division of a 40-bit dividend), each followed by one Newton update stage,
// the last of which is the output register. Divide uses the first divider;
// square root runs its four Newton steps through all four. Multiply, abs and
// the integer conversions finish early and ride along. The whole pipe moves
// on one enable, so a stalled output holds every stage; in_ready_o follows
// out_ready_i whenever the output register is full. Status is 1 only for a
// divide by zero, which returns 0; opcodes 6 and 7 return 0.
module q24_8_fixed_point_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    cmd_i,
  input  logic signed [qfa_pkg::DataW-1:0] operand_a_i,
  input  logic signed [qfa_pkg::DataW-1:0] operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [qfa_pkg::DataW-1:0] result_value_o,
  output logic                          status_o
);
  import qfa_pkg::*;

  logic en;

  // input stage
  logic                    va_q;
  logic [2:0]              cmd_a_q;
  logic signed [DataW-1:0] a_a_q, b_a_q;

  // multiplier stage
  logic                      vb_q;
  logic [2:0]                cmd_b_q;
  logic signed [DataW-1:0]   a_b_q, b_b_q;
  logic signed [2*DataW-1:0] prod_b_q;

  // operand stage
  logic            vc_q;
  sb_t             sb_c_d, sb_c_q;
  logic [DivW-1:0] num_c_d, num_c_q, den_c_d, den_c_q;

  // divider chain
  logic            dv_in  [NumDivs];
  sb_t             dsb_in [NumDivs];
  logic [DivW-1:0] dnum_in[NumDivs];
  logic [DivW-1:0] dden_in[NumDivs];
  logic            dv_out [NumDivs];
  sb_t             dsb_out[NumDivs];
  logic [DivW-1:0] dquo   [NumDivs];
  logic [DivW-1:0] dden   [NumDivs];

  // output register
  logic             out_valid_q;
  logic [DataW-1:0] res_q;
  logic             status_q;

  // advance the whole pipe unless the output holds an untaken beat
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_a_q  <= cmd_i;
      a_a_q    <= operand_a_i;
      b_a_q    <= operand_b_i;
      cmd_b_q  <= cmd_a_q;
      a_b_q    <= a_a_q;
      b_b_q    <= b_a_q;
      prod_b_q <= a_a_q * b_a_q;
      sb_c_q   <= sb_c_d;
      num_c_q  <= num_c_d;
      den_c_q  <= den_c_d;
    end
  end

  // operand stage: finish the single-step ops, set up the divider operands
  always_comb begin
    logic signed [2*DataW-1:0] prod_rnd;
    logic signed [DataW:0]     a_rnd;
    logic [DataW-1:0]          mag_a, mag_b;

    prod_rnd = prod_b_q[2*DataW-1] ? prod_b_q - 64'sd128 : prod_b_q + 64'sd128;
    a_rnd    = a_b_q[DataW-1] ? {a_b_q[DataW-1], a_b_q} - 33'sd128
                              : {a_b_q[DataW-1], a_b_q} + 33'sd128;
    mag_a    = a_b_q[DataW-1] ? DataW'(-a_b_q) : DataW'(a_b_q);
    mag_b    = b_b_q[DataW-1] ? DataW'(-b_b_q) : DataW'(b_b_q);

    sb_c_d        = '0;
    sb_c_d.cmd    = cmd_b_q;
    sb_c_d.s      = {a_b_q, {FracW{1'b0}}};
    sb_c_d.neg    = a_b_q[DataW-1] ^ b_b_q[DataW-1];
    sb_c_d.sqz    = a_b_q[DataW-1] || (a_b_q == '0);
    num_c_d       = {a_b_q, {FracW{1'b0}}};
    den_c_d       = {{(DivW-DataW){1'b0}}, a_b_q};

    unique case (cmd_b_q)
      CMD_MUL:   sb_c_d.res = prod_rnd[DataW+FracW-1:FracW];
      CMD_DIV: begin
        sb_c_d.status = (b_b_q == '0);
        num_c_d       = {mag_a, {FracW{1'b0}}};
        den_c_d       = {{(DivW-DataW){1'b0}}, mag_b};
      end
      CMD_SQRT:  sb_c_d.res = '0;
      CMD_ABS:   sb_c_d.res = mag_a;
      CMD_TRUNC: sb_c_d.res = DataW'(a_b_q >>> FracW);
      CMD_ROUND: sb_c_d.res = DataW'(a_rnd >>> FracW);
      default:   sb_c_d.res = '0;
    endcase
  end

  assign dv_in[0]   = vc_q;
  assign dsb_in[0]  = sb_c_q;
  assign dnum_in[0] = num_c_q;
  assign dden_in[0] = den_c_q;

  for (genvar u = 0; u < NumDivs; u++) begin : g_div
    qfa_divider u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_in[u]),
      .sb_i    (dsb_in[u]),
      .num_i   (dnum_in[u]),
      .den_i   (dden_in[u]),
      .valid_o (dv_out[u]),
      .sb_o    (dsb_out[u]),
      .quo_o   (dquo[u]),
      .den_o   (dden[u])
    );
  end

  // Newton update between dividers: x = (x + S/x) >> 1, feed S/x again
  for (genvar u = 0; u < NumDivs - 1; u++) begin : g_upd
    logic            v_q;
    sb_t             sb_d, sb_q;
    logic [DivW-1:0] x_d, x_q;
    logic [DivW:0]   sum;

    assign sum = {1'b0, dden[u]} + {1'b0, dquo[u]};
    assign x_d = sum[DivW:1];

    always_comb begin
      sb_d = dsb_out[u];
      // the first divider also serves the divide opcode
      if (u == 0 && dsb_out[u].cmd == CMD_DIV) begin
        if (dsb_out[u].status) begin
          sb_d.res = '0;
        end else begin
          sb_d.res = dsb_out[u].neg ? DataW'(-dquo[u][DataW-1:0]) : dquo[u][DataW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= dv_out[u];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sb_q <= sb_d;
        x_q  <= x_d;
      end
    end

    assign dv_in[u+1]   = v_q;
    assign dsb_in[u+1]  = sb_q;
    assign dnum_in[u+1] = sb_q.s;
    assign dden_in[u+1] = x_q;
  end

  // last Newton step, saturate, and land in the output register
  logic [DivW:0]    fin_sum;
  logic [DivW-1:0]  fin_x;
  logic [DataW-1:0] fin_sat, res_d;

  assign fin_sum = {1'b0, dden[NumDivs-1]} + {1'b0, dquo[NumDivs-1]};
  assign fin_x   = fin_sum[DivW:1];
  assign fin_sat = (fin_x > DivW'({1'b0, {(DataW-1){1'b1}}})) ? {1'b0, {(DataW-1){1'b1}}}
                                                              : fin_x[DataW-1:0];

  always_comb begin
    res_d = dsb_out[NumDivs-1].res;
    if (dsb_out[NumDivs-1].cmd == CMD_SQRT) begin
      res_d = dsb_out[NumDivs-1].sqz ? '0 : fin_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_out[NumDivs-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q    <= res_d;
      status_q <= dsb_out[NumDivs-1].status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;

endmodule
